[sv/dsf_pkg.sv]
// shared types and constants for the damped spring follower
package dsf_pkg;

	localparam int Q_W       = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int DVD_W     = 52;
	localparam int RAD_W     = 64;
	localparam int CNT_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION  = 3'd5;

	typedef enum logic {
		IU_DIV  = 1'b0,
		IU_SQRT = 1'b1
	} iu_op_t;

	typedef struct packed {
		logic   start;
		iu_op_t op;
	} iu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iu_rsp_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [67:0] hi;
		logic signed [67:0] lo;
		hi = 68'sh7FFFFFFF;
		lo = -68'sh80000000;
		if (v > hi) begin
			sat32 = 32'sh7FFFFFFF;
		end else if (v < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

[sv/dsf_if.sv]
// request channel interfaces: targets in, positions out, register writes
interface dsf_in_if;
	logic valid;
	logic ready;
	logic signed [dsf_pkg::Q_W-1:0] target_x;
	logic signed [dsf_pkg::Q_W-1:0] target_y;
	logic signed [dsf_pkg::Q_W-1:0] target_z;
	modport source(output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink(input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

interface dsf_out_if;
	logic valid;
	logic ready;
	logic signed [dsf_pkg::Q_W-1:0] pos_x;
	logic signed [dsf_pkg::Q_W-1:0] pos_y;
	logic signed [dsf_pkg::Q_W-1:0] pos_z;
	modport source(output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface dsf_cfg_if;
	logic valid;
	logic ready;
	logic [dsf_pkg::CFG_IDX_W-1:0] index;
	logic [dsf_pkg::CFG_DAT_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[sv/dsf_iter_unit.sv]
// shared iterative unit: restoring divide or integer square root, one bit a cycle
module dsf_iter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dsf_pkg::iu_req_t             req,
	input  logic [dsf_pkg::DVD_W-1:0]    dividend,
	input  logic [31:0]                  divisor,
	input  logic [dsf_pkg::RAD_W-1:0]    radicand,
	output dsf_pkg::iu_rsp_t             rsp,
	output logic [dsf_pkg::DVD_W-1:0]    result
);
	localparam logic [dsf_pkg::CNT_W-1:0] DIV_LAST  = 6'(dsf_pkg::DVD_W - 1);
	localparam logic [dsf_pkg::CNT_W-1:0] SQRT_LAST = 6'(dsf_pkg::RAD_W / 2 - 1);

	logic                       busy_q;
	logic                       done_q;
	dsf_pkg::iu_op_t            op_q;
	logic [dsf_pkg::CNT_W-1:0]  cnt_q;
	logic [dsf_pkg::RAD_W-1:0]  n_q;
	logic [33:0]                rem_q;
	logic [31:0]                root_q;
	logic [31:0]                d_q;

	logic [32:0] dt;
	logic        dge;
	logic [35:0] st;
	logic [35:0] trial;
	logic        sge;
	logic [dsf_pkg::RAD_W-1:0] n_next;
	logic [33:0] rem_next;

	// one step of either operation
	always_comb begin
		dt    = {rem_q[31:0], n_q[dsf_pkg::RAD_W-1]};
		dge   = dt >= {1'b0, d_q};
		st    = {rem_q, n_q[dsf_pkg::RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		sge   = st >= trial;
		if (op_q == dsf_pkg::IU_DIV) begin
			n_next   = {n_q[dsf_pkg::RAD_W-2:0], dge};
			rem_next = {2'b00, dge ? 32'(dt - {1'b0, d_q}) : dt[31:0]};
		end else begin
			n_next   = {n_q[dsf_pkg::RAD_W-3:0], 2'b00};
			rem_next = sge ? 34'(st - trial) : st[33:0];
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == dsf_pkg::IU_DIV) ? DIV_LAST : SQRT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			d_q    <= divisor;
			rem_q  <= '0;
			root_q <= '0;
			n_q    <= (req.op == dsf_pkg::IU_DIV) ?
				{dividend, {(dsf_pkg::RAD_W - dsf_pkg::DVD_W){1'b0}}} : radicand;
		end else if (busy_q) begin
			n_q   <= n_next;
			rem_q <= rem_next;
			if (op_q == dsf_pkg::IU_SQRT) begin
				root_q <= {root_q[30:0], sge};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = (op_q == dsf_pkg::IU_DIV) ? n_q[dsf_pkg::DVD_W-1:0] :
		{{(dsf_pkg::DVD_W - 32){1'b0}}, root_q};

endmodule

[sv/damped_spring_follow_step.sv]
// damped spring follower: one Euler step per request, Q16.16 state
// each request runs three 52-bit acceleration divides, one 32-bit root and up to three
// 52-bit friction divides, all in one shared bit-serial unit; one request at a time
// the next request is taken once the result sits in the output register
// reset: registers to defaults, position and velocity cleared at once, no clearing pass
module damped_spring_follow_step (
	input  logic         clk,
	input  logic         arst_n,
	dsf_cfg_if.sink      cfg,
	dsf_in_if.sink       targets,
	dsf_out_if.source    positions
);
	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_FMUL  = 18'h00002,
		S_FORCE = 18'h00004,
		S_ADIV  = 18'h00008,
		S_AWAIT = 18'h00010,
		S_DMUL  = 18'h00020,
		S_DAMP  = 18'h00040,
		S_SMUL  = 18'h00080,
		S_SACC  = 18'h00100,
		S_ROOT  = 18'h00200,
		S_RWAIT = 18'h00400,
		S_LCHK  = 18'h00800,
		S_RMUL  = 18'h01000,
		S_FDIV  = 18'h02000,
		S_FWAIT = 18'h04000,
		S_PMUL  = 18'h08000,
		S_POS   = 18'h10000,
		S_OUT   = 18'h20000
	} state_t;

	state_t state_q;

	logic [16:0]        env_q;
	logic [16:0]        damp_q;
	logic [16:0]        k_q;
	logic [25:0]        mass_q;
	logic signed [23:0] grav_q;
	logic [19:0]        fric_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] tgt_q [3];
	logic [1:0]         axis_q;
	logic signed [34:0] force_q;
	logic signed [31:0] acc_q;
	logic               sign_q;
	logic signed [67:0] prod_q;
	logic [63:0]        sq_q;
	logic [31:0]        len_q;
	logic               out_valid_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic signed [31:0] out_z_q;

	dsf_pkg::iu_req_t             iu_req;
	dsf_pkg::iu_rsp_t             iu_rsp;
	logic [dsf_pkg::DVD_W-1:0]    iu_dividend;
	logic [31:0]                  iu_divisor;
	logic [dsf_pkg::DVD_W-1:0]    iu_result;

	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [32:0] diff;
	logic signed [32:0] vsum;
	logic signed [32:0] psum;
	logic signed [67:0] negp;
	logic signed [34:0] force_c;
	logic [34:0]        force_mag;
	logic [67:0]        prod_mag;
	logic [25:0]        mass_eff;
	logic signed [31:0] acc_c;
	logic signed [32:0] fr_c;
	logic signed [33:0] vfric;

	// saturated signed value from a quotient magnitude and its sign
	function automatic logic signed [31:0] sat_mag(input logic [51:0] q, input logic neg);
		if (!neg) begin
			sat_mag = (q > 52'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
		end else begin
			sat_mag = (q > 52'h80000000) ? 32'sh80000000 : 32'(-q[31:0]);
		end
	endfunction

	// register writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= 17'd65536;
			damp_q <= 17'd6554;
			k_q    <= 17'd58982;
			mass_q <= 26'd65536;
			grav_q <= 24'sd642253;
			fric_q <= 20'd6554;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dsf_pkg::REG_ENVELOPE:  env_q  <= cfg.data[16:0];
				dsf_pkg::REG_DAMPING:   damp_q <= cfg.data[16:0];
				dsf_pkg::REG_STIFFNESS: k_q    <= cfg.data[16:0];
				dsf_pkg::REG_MASS:      mass_q <= cfg.data[25:0];
				dsf_pkg::REG_GRAVITY:   grav_q <= cfg.data[23:0];
				dsf_pkg::REG_FRICTION:  fric_q <= cfg.data[19:0];
				default: ;
			endcase
		end
	end

	// per-axis arithmetic around the shared multiplier
	always_comb begin
		diff      = 33'(pos_q[axis_q]) - 33'(tgt_q[axis_q]);
		vsum      = 33'(vel_q[axis_q]) + 33'(acc_q);
		psum      = 33'(pos_q[axis_q]) + 33'(vel_q[axis_q]);
		negp      = -prod_q;
		force_c   = 35'(negp >>> 16) - ((axis_q == 2'd1) ? 35'(grav_q) : 35'sd0);
		force_mag = force_q[34] ? 35'(-force_q) : force_q;
		prod_mag  = prod_q[67] ? 68'(negp) : 68'(prod_q);
		mass_eff  = (mass_q < 26'd66) ? 26'd66 : mass_q;
		acc_c     = sat_mag(iu_result, sign_q);
		fr_c      = sign_q ? -33'(iu_result[31:0]) : 33'(iu_result[31:0]);
		vfric     = 34'(vel_q[axis_q]) - 34'(fr_c);
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_FMUL: begin
				mul_a = 34'(k_q);
				mul_b = 34'(diff);
			end
			S_DMUL: begin
				mul_a = 34'(damp_q);
				mul_b = 34'(vsum);
			end
			S_SMUL: begin
				mul_a = 34'(vel_q[axis_q]);
				mul_b = 34'(vel_q[axis_q]);
			end
			S_RMUL: begin
				mul_a = 34'(fric_q);
				mul_b = 34'(vel_q[axis_q]);
			end
			S_PMUL: begin
				mul_a = 34'(env_q);
				mul_b = 34'(psum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// shared unit requests
	always_comb begin
		iu_req.start = (state_q == S_ADIV) || (state_q == S_FDIV) || (state_q == S_ROOT);
		iu_req.op    = (state_q == S_ROOT) ? dsf_pkg::IU_SQRT : dsf_pkg::IU_DIV;
		iu_dividend  = (state_q == S_ADIV) ? {1'b0, force_mag, 16'd0} : prod_mag[51:0];
		iu_divisor   = (state_q == S_ADIV) ? 32'(mass_eff) : len_q;
	end

	dsf_iter_unit u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (iu_req),
		.dividend (iu_dividend),
		.divisor  (iu_divisor),
		.radicand (sq_q),
		.rsp      (iu_rsp),
		.result   (iu_result)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (positions.valid && positions.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (targets.valid) begin
						axis_q  <= '0;
						state_q <= S_FMUL;
					end
				end
				S_FMUL:  state_q <= S_FORCE;
				S_FORCE: state_q <= S_ADIV;
				S_ADIV:  state_q <= S_AWAIT;
				S_AWAIT: begin
					if (iu_rsp.done) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: state_q <= S_DAMP;
				S_DAMP: begin
					vel_q[axis_q] <= dsf_pkg::sat32(prod_q >>> 16);
					state_q       <= S_SMUL;
				end
				S_SMUL: state_q <= S_SACC;
				S_SACC: begin
					if (axis_q == 2'd2) begin
						axis_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_FMUL;
					end
				end
				S_ROOT: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (iu_rsp.done) begin
						state_q <= S_LCHK;
					end
				end
				S_LCHK:  state_q <= (len_q == '0) ? S_PMUL : S_RMUL;
				S_RMUL:  state_q <= S_FDIV;
				S_FDIV:  state_q <= S_FWAIT;
				S_FWAIT: begin
					if (iu_rsp.done) begin
						vel_q[axis_q] <= dsf_pkg::sat32(68'(vfric));
						state_q       <= S_PMUL;
					end
				end
				S_PMUL: state_q <= S_POS;
				S_POS: begin
					pos_q[axis_q] <= dsf_pkg::sat32(prod_q >>> 16);
					if (axis_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_LCHK;
					end
				end
				S_OUT: begin
					if (!out_valid_q || positions.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && targets.valid) begin
			tgt_q[0] <= targets.target_x;
			tgt_q[1] <= targets.target_y;
			tgt_q[2] <= targets.target_z;
		end
		if (state_q == S_FORCE) begin
			force_q <= force_c;
		end
		if (state_q == S_ADIV) begin
			sign_q <= force_q[34];
		end
		if (state_q == S_FDIV) begin
			sign_q <= prod_q[67];
		end
		if (state_q == S_AWAIT && iu_rsp.done) begin
			acc_q <= acc_c;
		end
		if (state_q == S_SACC) begin
			sq_q <= ((axis_q == 2'd0) ? 64'd0 : sq_q) + prod_q[63:0];
		end
		if (state_q == S_RWAIT && iu_rsp.done) begin
			len_q <= iu_result[31:0];
		end
		if (state_q == S_OUT && (!out_valid_q || positions.ready)) begin
			out_x_q <= pos_q[0];
			out_y_q <= pos_q[1];
			out_z_q <= pos_q[2];
		end
	end

	assign targets.ready   = (state_q == S_IDLE);
	assign positions.valid = out_valid_q;
	assign positions.pos_x = out_x_q;
	assign positions.pos_y = out_y_q;
	assign positions.pos_z = out_z_q;

endmodule

[sv/dsf_checker.sv]
// port-level checks for the damped spring follower, bound to the top level
module dsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [31:0] out_z
);
	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready high right after an accepted request");

	// a result never rises right after an accepted request
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after a request");

	// stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("result changed while stalled");

endmodule

bind damped_spring_follow_step dsf_checker u_dsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (targets.valid),
	.in_ready  (targets.ready),
	.out_valid (positions.valid),
	.out_ready (positions.ready),
	.out_x     (positions.pos_x),
	.out_y     (positions.pos_y),
	.out_z     (positions.pos_z)
);
